// ===== rtl/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

  // Word and internal widths
  localparam int WORD_BITS  = 32;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int QUOT_BITS  = WORD_BITS + 1;
  localparam int ROOT_BITS  = WORD_BITS;
  localparam int SQREM_BITS = WORD_BITS + 3;
  localparam int CX_BITS    = WORD_BITS + 3;
  localparam int CZ_BITS    = WORD_BITS + 2;

  // Defaults of the top-level parameters
  localparam int FRAC_BITS_DEFAULT     = 16;
  localparam int CORDIC_STAGES_DEFAULT = 16;

  // Operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_MAG   = 3'd4;
  localparam logic [2:0] OP_PHASE = 3'd5;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [2:0]                  operation;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_re;
    logic signed [WORD_BITS-1:0] result_im;
    logic                        saturated;
    logic                        divide_by_zero;
  } out_item_t;

  // State of one item as it moves down the cell row
  typedef struct packed {
    logic [2:0]                  op;
    logic [WORD_BITS-1:0]        dir_re;   // finished result for add/sub/mul/zero divide
    logic [WORD_BITS-1:0]        dir_im;
    logic                        dir_sat;
    logic                        dir_dz;
    logic [PROD_BITS-1:0]        den;
    logic [PROD_BITS-1:0]        num_re;
    logic [PROD_BITS-1:0]        num_im;
    logic [PROD_BITS-1:0]        rem_re;
    logic [PROD_BITS-1:0]        rem_im;
    logic [QUOT_BITS-1:0]        q_re;
    logic [QUOT_BITS-1:0]        q_im;
    logic                        big_re;
    logic                        big_im;
    logic                        neg_re;
    logic                        neg_im;
    logic [PROD_BITS-1:0]        sq_s;
    logic [SQREM_BITS-1:0]       sq_rem;
    logic [ROOT_BITS-1:0]        sq_root;
    logic signed [CX_BITS-1:0]   cx;
    logic signed [CX_BITS-1:0]   cy;
    logic signed [CZ_BITS-1:0]   cz;
    logic                        czero;
  } cell_t;

  // Number of cells: the divide needs one step per numerator bit plus fraction bits
  function automatic int cell_count(int frac);
    return PROD_BITS + frac;
  endfunction

  // Q30 angle rounded to frac fraction bits
  function automatic logic [CZ_BITS-1:0] round_q30(logic [63:0] t, int frac);
    int          sh;
    logic [63:0] r;
    sh = 30 - frac;
    if (sh <= 0) begin
      r = t;
    end else begin
      r = (t + (64'd1 << (sh - 1))) >> sh;
    end
    return r[CZ_BITS-1:0];
  endfunction

  // atan(2^-idx) at frac fraction bits
  function automatic logic [CZ_BITS-1:0] cordic_angle(int idx, int frac);
    logic [63:0] t;
    case (idx)
      0:  t = 64'h3243F6A8;
      1:  t = 64'h1DAC6705;
      2:  t = 64'h0FADBAFC;
      3:  t = 64'h07F56EA6;
      4:  t = 64'h03FEAB76;
      5:  t = 64'h01FFD55B;
      6:  t = 64'h00FFFAAA;
      7:  t = 64'h007FFF55;
      8:  t = 64'h003FFFEA;
      9:  t = 64'h001FFFFD;
      10: t = 64'h000FFFFF;
      11: t = 64'h0007FFFF;
      12: t = 64'h0003FFFF;
      13: t = 64'h0001FFFF;
      14: t = 64'h0000FFFF;
      15: t = 64'h00007FFF;
      16: t = 64'h00003FFF;
      17: t = 64'h00001FFF;
      18: t = 64'h00000FFF;
      19: t = 64'h000007FF;
      20: t = 64'h000003FF;
      21: t = 64'h000001FF;
      22: t = 64'h000000FF;
      23: t = 64'h0000007F;
      24: t = 64'h0000003F;
      25: t = 64'h0000001F;
      26: t = 64'h0000000F;
      27: t = 64'h00000008;
      28: t = 64'h00000004;
      29: t = 64'h00000002;
      30: t = 64'h00000001;
      default: t = 64'h0;
    endcase
    return round_q30(t, frac);
  endfunction

  function automatic logic [CZ_BITS-1:0] half_pi_angle(int frac);
    return round_q30(64'd1686629713, frac);
  endfunction

  // Clamp a one-bit-grown sum to the word range: {sat, value}
  function automatic logic [WORD_BITS:0] clamp_grown(logic [WORD_BITS:0] v);
    logic [WORD_BITS:0] r;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r = {1'b1, (v[WORD_BITS] ? WORD_MIN : WORD_MAX)};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/cau_front.sv =====
// Input register, product stage and preparation stage feeding the cell row.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  cau_pkg::in_item_t in_item,
  output logic              out_valid,
  output cau_pkg::cell_t    out_cell
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PB = cau_pkg::PROD_BITS;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [W-1:0]  ar;
    logic signed [W-1:0]  ai;
    logic signed [PB-1:0] p_rr;
    logic signed [PB-1:0] p_ii;
    logic signed [PB-1:0] p_ri;
    logic signed [PB-1:0] p_ir;
    logic [PB-1:0]        sq0;
    logic [PB-1:0]        sq1;
    logic [W-1:0]         dir_re;
    logic [W-1:0]         dir_im;
    logic                 dir_sat;
    logic                 dir_dz;
  } prod_t;

  cau_pkg::in_item_t s1;
  logic              s1_valid;
  prod_t             s2;
  prod_t             s2_next;
  logic              s2_valid;
  cau_pkg::cell_t    cell_next;

  logic signed [W-1:0]  m0;
  logic signed [W-1:0]  m1;
  logic signed [PB-1:0] sq0_s;
  logic signed [PB-1:0] sq1_s;
  logic [W:0]           add_re;
  logic [W:0]           add_im;
  logic [W:0]           sub_re;
  logic [W:0]           sub_im;
  logic                 b_zero;

  // Products and the direct add, subtract and zero-divide results
  always_comb begin
    m0    = (s1.operation == cau_pkg::OP_MAG) ? s1.a_re : s1.b_re;
    m1    = (s1.operation == cau_pkg::OP_MAG) ? s1.a_im : s1.b_im;
    sq0_s = m0 * m0;
    sq1_s = m1 * m1;
    add_re = cau_pkg::clamp_grown({s1.a_re[W-1], s1.a_re} + {s1.b_re[W-1], s1.b_re});
    add_im = cau_pkg::clamp_grown({s1.a_im[W-1], s1.a_im} + {s1.b_im[W-1], s1.b_im});
    sub_re = cau_pkg::clamp_grown({s1.a_re[W-1], s1.a_re} - {s1.b_re[W-1], s1.b_re});
    sub_im = cau_pkg::clamp_grown({s1.a_im[W-1], s1.a_im} - {s1.b_im[W-1], s1.b_im});
    b_zero = (s1.b_re == '0) && (s1.b_im == '0);

    s2_next.op   = s1.operation;
    s2_next.ar   = s1.a_re;
    s2_next.ai   = s1.a_im;
    s2_next.p_rr = s1.a_re * s1.b_re;
    s2_next.p_ii = s1.a_im * s1.b_im;
    s2_next.p_ri = s1.a_re * s1.b_im;
    s2_next.p_ir = s1.a_im * s1.b_re;
    s2_next.sq0  = sq0_s;
    s2_next.sq1  = sq1_s;
    s2_next.dir_re  = '0;
    s2_next.dir_im  = '0;
    s2_next.dir_sat = 1'b0;
    s2_next.dir_dz  = 1'b0;
    unique case (s1.operation)
      cau_pkg::OP_ADD: begin
        s2_next.dir_re  = add_re[W-1:0];
        s2_next.dir_im  = add_im[W-1:0];
        s2_next.dir_sat = add_re[W] | add_im[W];
      end
      cau_pkg::OP_SUB: begin
        s2_next.dir_re  = sub_re[W-1:0];
        s2_next.dir_im  = sub_im[W-1:0];
        s2_next.dir_sat = sub_re[W] | sub_im[W];
      end
      cau_pkg::OP_DIV: begin
        // zero divisor: parts saturate by the sign of a
        s2_next.dir_dz = b_zero;
        s2_next.dir_re = s1.a_re[W-1] ? cau_pkg::WORD_MIN :
                         (s1.a_re != '0 ? cau_pkg::WORD_MAX : '0);
        s2_next.dir_im = s1.a_im[W-1] ? cau_pkg::WORD_MIN :
                         (s1.a_im != '0 ? cau_pkg::WORD_MAX : '0);
      end
      default: begin
      end
    endcase
  end

  logic signed [PB:0] mul_re;
  logic signed [PB:0] mul_im;
  logic signed [PB:0] mul_re_sh;
  logic signed [PB:0] mul_im_sh;
  logic               mul_re_ok;
  logic               mul_im_ok;
  logic signed [PB:0] div_re;
  logic signed [PB:0] div_im;
  logic [PB:0]        div_re_neg;
  logic [PB:0]        div_im_neg;
  logic [PB-1:0]      sq_sum;
  logic signed [cau_pkg::CX_BITS-1:0] xa;
  logic signed [cau_pkg::CX_BITS-1:0] ya;

  // Sums, multiply result, divide operands and the CORDIC quarter-turn
  always_comb begin
    mul_re    = {s2.p_rr[PB-1], s2.p_rr} - {s2.p_ii[PB-1], s2.p_ii};
    mul_im    = {s2.p_ri[PB-1], s2.p_ri} + {s2.p_ir[PB-1], s2.p_ir};
    mul_re_sh = mul_re >>> FRAC_BITS;
    mul_im_sh = mul_im >>> FRAC_BITS;
    mul_re_ok = (&mul_re_sh[PB:W-1]) | ~(|mul_re_sh[PB:W-1]);
    mul_im_ok = (&mul_im_sh[PB:W-1]) | ~(|mul_im_sh[PB:W-1]);
    div_re    = {s2.p_rr[PB-1], s2.p_rr} + {s2.p_ii[PB-1], s2.p_ii};
    div_im    = {s2.p_ir[PB-1], s2.p_ir} - {s2.p_ri[PB-1], s2.p_ri};
    div_re_neg = -div_re;
    div_im_neg = -div_im;
    sq_sum    = s2.sq0 + s2.sq1;
    xa        = {{(cau_pkg::CX_BITS-W){s2.ar[W-1]}}, s2.ar};
    ya        = {{(cau_pkg::CX_BITS-W){s2.ai[W-1]}}, s2.ai};

    cell_next.op      = s2.op;
    cell_next.dir_re  = s2.dir_re;
    cell_next.dir_im  = s2.dir_im;
    cell_next.dir_sat = s2.dir_sat;
    cell_next.dir_dz  = s2.dir_dz;
    if (s2.op == cau_pkg::OP_MUL) begin
      cell_next.dir_re  = mul_re_ok ? mul_re_sh[W-1:0] :
                          (mul_re_sh[PB] ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX);
      cell_next.dir_im  = mul_im_ok ? mul_im_sh[W-1:0] :
                          (mul_im_sh[PB] ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX);
      cell_next.dir_sat = ~mul_re_ok | ~mul_im_ok;
    end
    cell_next.den     = sq_sum;
    cell_next.neg_re  = div_re[PB];
    cell_next.neg_im  = div_im[PB];
    cell_next.num_re  = div_re[PB] ? div_re_neg[PB-1:0] : div_re[PB-1:0];
    cell_next.num_im  = div_im[PB] ? div_im_neg[PB-1:0] : div_im[PB-1:0];
    cell_next.rem_re  = '0;
    cell_next.rem_im  = '0;
    cell_next.q_re    = '0;
    cell_next.q_im    = '0;
    cell_next.big_re  = 1'b0;
    cell_next.big_im  = 1'b0;
    cell_next.sq_s    = sq_sum;
    cell_next.sq_rem  = '0;
    cell_next.sq_root = '0;
    cell_next.czero   = (s2.ar == '0) && (s2.ai == '0);
    if (s2.ar[W-1]) begin
      if (!s2.ai[W-1]) begin
        cell_next.cx = ya;
        cell_next.cy = -xa;
        cell_next.cz = cau_pkg::half_pi_angle(FRAC_BITS);
      end else begin
        cell_next.cx = -ya;
        cell_next.cy = xa;
        cell_next.cz = -cau_pkg::half_pi_angle(FRAC_BITS);
      end
    end else begin
      cell_next.cx = xa;
      cell_next.cy = ya;
      cell_next.cz = '0;
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1       <= in_item;
      s2       <= s2_next;
      out_cell <= cell_next;
    end
  end

endmodule

// ===== rtl/cau_cell.sv =====
// One cell: divide step for both parts; root step if INDEX < RB; CORDIC step if INDEX < CORDIC_STAGES.
module cau_cell #(
  parameter int INDEX         = 0,
  parameter int FRAC_BITS     = cau_pkg::FRAC_BITS_DEFAULT,
  parameter int CORDIC_STAGES = cau_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cau_pkg::cell_t in_cell,
  output logic           out_valid,
  output cau_pkg::cell_t out_cell
);

  localparam int PB = cau_pkg::PROD_BITS;
  localparam int QB = cau_pkg::QUOT_BITS;
  localparam int RB = cau_pkg::ROOT_BITS;
  localparam int SB = cau_pkg::SQREM_BITS;
  localparam logic [cau_pkg::CZ_BITS-1:0] ANG = cau_pkg::cordic_angle(INDEX, FRAC_BITS);

  cau_pkg::cell_t cell_next;
  logic [PB:0]    sh_re;
  logic [PB:0]    sh_im;
  logic [PB:0]    df_re;
  logic [PB:0]    df_im;
  logic           ge_re;
  logic           ge_im;
  logic [SB-1:0]  sq_sh;
  logic [SB-1:0]  sq_trial;
  logic [SB-1:0]  sq_df;
  logic           sq_ge;
  logic signed [cau_pkg::CX_BITS-1:0] dx;
  logic signed [cau_pkg::CX_BITS-1:0] dy;

  always_comb begin
    cell_next = in_cell;

    // restoring divide step, one numerator bit
    sh_re = {in_cell.rem_re, in_cell.num_re[PB-1]};
    sh_im = {in_cell.rem_im, in_cell.num_im[PB-1]};
    df_re = sh_re - {1'b0, in_cell.den};
    df_im = sh_im - {1'b0, in_cell.den};
    ge_re = sh_re >= {1'b0, in_cell.den};
    ge_im = sh_im >= {1'b0, in_cell.den};
    cell_next.rem_re = ge_re ? df_re[PB-1:0] : sh_re[PB-1:0];
    cell_next.rem_im = ge_im ? df_im[PB-1:0] : sh_im[PB-1:0];
    cell_next.num_re = {in_cell.num_re[PB-2:0], 1'b0};
    cell_next.num_im = {in_cell.num_im[PB-2:0], 1'b0};
    cell_next.big_re = in_cell.big_re | in_cell.q_re[QB-1];
    cell_next.big_im = in_cell.big_im | in_cell.q_im[QB-1];
    cell_next.q_re   = {in_cell.q_re[QB-2:0], ge_re};
    cell_next.q_im   = {in_cell.q_im[QB-2:0], ge_im};

    // square root step, two radicand bits
    sq_sh    = {in_cell.sq_rem[SB-3:0], in_cell.sq_s[PB-1:PB-2]};
    sq_trial = {{(SB-RB-2){1'b0}}, in_cell.sq_root, 2'b01};
    sq_df    = sq_sh - sq_trial;
    sq_ge    = sq_sh >= sq_trial;
    if (INDEX < RB) begin
      cell_next.sq_rem  = sq_ge ? sq_df : sq_sh;
      cell_next.sq_root = {in_cell.sq_root[RB-2:0], sq_ge};
      cell_next.sq_s    = {in_cell.sq_s[PB-3:0], 2'b00};
    end

    // vectoring CORDIC iteration
    dx = in_cell.cy >>> INDEX;
    dy = in_cell.cx >>> INDEX;
    if (INDEX < CORDIC_STAGES) begin
      if (!in_cell.cy[cau_pkg::CX_BITS-1]) begin
        cell_next.cx = in_cell.cx + dx;
        cell_next.cy = in_cell.cy - dy;
        cell_next.cz = in_cell.cz + ANG;
      end else begin
        cell_next.cx = in_cell.cx - dx;
        cell_next.cy = in_cell.cy + dy;
        cell_next.cz = in_cell.cz - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cell <= cell_next;
    end
  end

endmodule

// ===== rtl/cau_out_buffer.sv =====
// Two-entry result buffer that decouples the cell row from the receiver.
module cau_out_buffer (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cau_pkg::out_item_t push_item,
  output logic               space,
  output logic               result_valid,
  input  logic               result_ready,
  output cau_pkg::out_item_t result
);

  cau_pkg::out_item_t entry0;
  cau_pkg::out_item_t entry1;
  logic [1:0]         count;
  logic               pop;

  assign result_valid = (count != 2'd0);
  assign result       = entry0;
  assign space        = (count != 2'd2);
  assign pop          = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entry0 is the head
  always_ff @(posedge clk) begin
    if (pop) begin
      entry0 <= (count == 2'd2) ? entry1 : push_item;
      if (push && count == 2'd2) begin
        entry1 <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        entry0 <= push_item;
      end else begin
        entry1 <= push_item;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !space))
    else $error("result buffer pushed while full");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> !space)
    else $error("result buffer lost an item");
`endif

endmodule

// ===== rtl/complex_arithmetic_unit_core.sv =====
// Top level of the complex arithmetic unit: front stages, cell row, result buffer.
//
// Usage: operands enter on operand_valid/operand_ready as one item (operation, a, b in
// signed fixed point with FRAC_BITS fraction bits); one result item leaves on
// result_valid/result_ready for every item accepted, in order.
// Add, subtract and multiply finish in the front stages; divide, magnitude and
// phase are worked out in a row of 2*WORD_BITS+FRAC_BITS cells, one quotient bit per
// cell, a root step in each of the first ROOT_BITS cells and a CORDIC iteration in
// each of the first CORDIC_STAGES cells; all items ride the row. Throughput: one
// item per cycle while the result buffer has room; the cell row advances whenever
// the pipeline is not held.
// A two-entry buffer holds finished items; the pipeline keeps moving while it has
// room, so items are still accepted while a result waits. When it is full the
// whole pipeline holds and operand_ready drops.
// Reset (rst, synchronous) clears the valid bits of every stage and empties
// the buffer; no item is in flight afterwards.
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS     = cau_pkg::FRAC_BITS_DEFAULT,
  parameter int CORDIC_STAGES = cau_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               operand_valid,
  output logic               operand_ready,
  input  cau_pkg::in_item_t  operand,
  output logic               result_valid,
  input  logic               result_ready,
  output cau_pkg::out_item_t result
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int QB = cau_pkg::QUOT_BITS;
  localparam int N  = cau_pkg::cell_count(FRAC_BITS);

  logic               adv;
  logic               chain_valid [N+1];
  cau_pkg::cell_t     chain       [N+1];
  cau_pkg::cell_t     last;
  cau_pkg::out_item_t fin;
  logic               sat_re;
  logic               sat_im;
  logic [W-1:0]       neg_q_re;
  logic [W-1:0]       neg_q_im;
  logic [W-1:0]       val_re;
  logic [W-1:0]       val_im;
  logic               z_ok;

  assign operand_ready = adv;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (operand_valid),
    .in_item  (operand),
    .out_valid(chain_valid[0]),
    .out_cell (chain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    cau_cell #(
      .INDEX        (i),
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (chain_valid[i]),
      .in_cell  (chain[i]),
      .out_valid(chain_valid[i+1]),
      .out_cell (chain[i+1])
    );
  end

  // Result selection and final saturation
  always_comb begin
    last     = chain[N];
    neg_q_re = -last.q_re[W-1:0];
    neg_q_im = -last.q_im[W-1:0];
    if (last.neg_re) begin
      sat_re = last.big_re | last.q_re[QB-1] | (last.q_re[W-1] & (|last.q_re[W-2:0]));
      val_re = sat_re ? cau_pkg::WORD_MIN : neg_q_re;
    end else begin
      sat_re = last.big_re | last.q_re[QB-1] | last.q_re[W-1];
      val_re = sat_re ? cau_pkg::WORD_MAX : last.q_re[W-1:0];
    end
    if (last.neg_im) begin
      sat_im = last.big_im | last.q_im[QB-1] | (last.q_im[W-1] & (|last.q_im[W-2:0]));
      val_im = sat_im ? cau_pkg::WORD_MIN : neg_q_im;
    end else begin
      sat_im = last.big_im | last.q_im[QB-1] | last.q_im[W-1];
      val_im = sat_im ? cau_pkg::WORD_MAX : last.q_im[W-1:0];
    end
    z_ok = (&last.cz[cau_pkg::CZ_BITS-1:W-1]) | ~(|last.cz[cau_pkg::CZ_BITS-1:W-1]);

    fin = '0;
    unique case (last.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        fin.result_re = last.dir_re;
        fin.result_im = last.dir_im;
        fin.saturated = last.dir_sat;
      end
      cau_pkg::OP_DIV: begin
        if (last.dir_dz) begin
          fin.result_re      = last.dir_re;
          fin.result_im      = last.dir_im;
          fin.divide_by_zero = 1'b1;
        end else begin
          fin.result_re = val_re;
          fin.result_im = val_im;
          fin.saturated = sat_re | sat_im;
        end
      end
      cau_pkg::OP_MAG: begin
        fin.saturated = last.sq_root[W-1];
        fin.result_re = last.sq_root[W-1] ? cau_pkg::WORD_MAX : last.sq_root;
      end
      cau_pkg::OP_PHASE: begin
        if (!last.czero) begin
          fin.saturated = ~z_ok;
          fin.result_re = z_ok ? last.cz[W-1:0] :
                          (last.cz[cau_pkg::CZ_BITS-1] ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX);
        end
      end
      default: begin
      end
    endcase
  end

  cau_out_buffer u_buffer (
    .clk         (clk),
    .rst         (rst),
    .push        (chain_valid[N] && adv),
    .push_item   (fin),
    .space       (adv),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

`ifndef SYNTH
  a_dz_not_sat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.divide_by_zero) |-> !result.saturated)
    else $error("divide by zero result also flagged saturated");
  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    (chain_valid[N] && !adv) |=> chain_valid[N])
    else $error("item at end of cell row dropped during stall");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the complex arithmetic unit core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int STAGES = 16;
  localparam int LATENCY = 2 * cau_pkg::WORD_BITS + FRAC + 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic operand_valid = 1'b0;
  logic operand_ready;
  cau_pkg::in_item_t operand = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  cau_pkg::out_item_t result;

  complex_arithmetic_unit_core #(.FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst),
    .operand_valid(operand_valid), .operand_ready(operand_ready), .operand(operand),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #5 clk = ~clk;

  cau_pkg::in_item_t  pending_items[$];
  cau_pkg::out_item_t expected_results[$];
  int errors = 0;
  int accepted_in = 0;
  int accepted_out = 0;
  int op_seen[8];
  bit stim_done = 1'b0;
  bit hold_done = 1'b0;
  bit hold_active = 1'b0;
  int idle_cycles = 0;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  // atan(2^-i) in Q30
  function automatic longint atan_q30(int i);
    case (i)
      0: return 64'h3243F6A8;  1: return 64'h1DAC6705;  2: return 64'h0FADBAFC;
      3: return 64'h07F56EA6;  4: return 64'h03FEAB76;  5: return 64'h01FFD55B;
      6: return 64'h00FFFAAA;  7: return 64'h007FFF55;  8: return 64'h003FFFEA;
      9: return 64'h001FFFFD;  10: return 64'h000FFFFF; 11: return 64'h0007FFFF;
      12: return 64'h0003FFFF; 13: return 64'h0001FFFF; 14: return 64'h0000FFFF;
      15: return 64'h00007FFF; 16: return 64'h00003FFF; 17: return 64'h00001FFF;
      18: return 64'h00000FFF; 19: return 64'h000007FF; 20: return 64'h000003FF;
      21: return 64'h000001FF; 22: return 64'h000000FF; 23: return 64'h0000007F;
      24: return 64'h0000003F; 25: return 64'h0000001F; 26: return 64'h0000000F;
      27: return 64'h00000008; 28: return 64'h00000004; 29: return 64'h00000002;
      30: return 64'h00000001;
      default: return 0;
    endcase
  endfunction

  function automatic longint q30_to_frac(longint t);
    int sh;
    sh = 30 - FRAC;
    if (sh <= 0) return t;
    return (t + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_word(longint v, inout bit sat);
    if (v > WMAX) begin
      sat = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  // signed magnitude to word, with quotient overflow flag
  function automatic longint mag_to_word(bit neg, logic [63:0] m, bit big, inout bit sat);
    if (!neg) begin
      if (big || m > 64'd2147483647) begin
        sat = 1'b1;
        return WMAX;
      end
      return longint'(m);
    end
    if (big || m > 64'd2147483648) begin
      sat = 1'b1;
      return WMIN;
    end
    return -longint'(m);
  endfunction

  // exact fractional quotient of magnitudes: (num << FRAC) / den
  function automatic logic [63:0] frac_quotient(logic [63:0] num, logic [63:0] den,
                                                 inout bit big);
    logic [127:0] wide;
    logic [127:0] q;
    wide = {64'd0, num} << FRAC;
    q = wide / {64'd0, den};
    if (q[127:63] != 0) big = 1'b1;
    return q[63:0];
  endfunction

  // sign and magnitude of p + q using 66-bit signed math
  function automatic logic [63:0] signed_mag(logic signed [65:0] s, output bit neg);
    neg = s < 0;
    if (neg) s = -s;
    return s[63:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint cordic_phase(longint x, longint y);
    longint z, nx, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; y = -x; z = q30_to_frac(1686629713);
      end else begin
        nx = -y; y = x; z = -q30_to_frac(1686629713);
      end
      x = nx;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += q30_to_frac(atan_q30(i));
      end else begin
        x -= dx; y += dy; z -= q30_to_frac(atan_q30(i));
      end
    end
    return z;
  endfunction

  function automatic cau_pkg::out_item_t predict_result(cau_pkg::in_item_t it);
    cau_pkg::out_item_t r;
    longint ar, ai, br, bi, re, im;
    logic signed [65:0] s;
    logic [63:0] den, m, q;
    bit sat, dz, neg, big;
    ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
    re = 0; im = 0; sat = 0; dz = 0;
    case (it.operation)
      cau_pkg::OP_ADD: begin
        re = clamp_word(ar + br, sat);
        im = clamp_word(ai + bi, sat);
      end
      cau_pkg::OP_SUB: begin
        re = clamp_word(ar - br, sat);
        im = clamp_word(ai - bi, sat);
      end
      cau_pkg::OP_MUL: begin
        s = 66'(ar * br) - 66'(ai * bi);
        re = clamp_word(longint'(s >>> FRAC), sat);
        s = 66'(ar * bi) + 66'(ai * br);
        im = clamp_word(longint'(s >>> FRAC), sat);
      end
      cau_pkg::OP_DIV: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (br == 0 && bi == 0) begin
          dz = 1;
          re = ar > 0 ? WMAX : (ar < 0 ? WMIN : 0);
          im = ai > 0 ? WMAX : (ai < 0 ? WMIN : 0);
        end else begin
          s = 66'(ar * br) + 66'(ai * bi);
          m = signed_mag(s, neg);
          big = 0;
          q = frac_quotient(m, den, big);
          re = mag_to_word(neg, q, big, sat);
          s = 66'(ai * br) - 66'(ar * bi);
          m = signed_mag(s, neg);
          big = 0;
          q = frac_quotient(m, den, big);
          im = mag_to_word(neg, q, big, sat);
        end
      end
      cau_pkg::OP_MAG: begin
        m = 64'(ar * ar) + 64'(ai * ai);
        re = mag_to_word(0, floor_sqrt(m), 0, sat);
      end
      cau_pkg::OP_PHASE: re = clamp_word(cordic_phase(ar, ai), sat);
      default: ;
    endcase
    r.result_re = re[31:0];
    r.result_im = im[31:0];
    r.saturated = sat;
    r.divide_by_zero = dz;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      4: return 32'($signed($urandom_range(0, 200000)) - 100000);
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic cau_pkg::in_item_t make_item(logic [2:0] op, logic [31:0] ar,
                                                  logic [31:0] ai, logic [31:0] br,
                                                  logic [31:0] bi);
    cau_pkg::in_item_t it;
    it.operation = op; it.a_re = ar; it.a_im = ai; it.b_re = br; it.b_im = bi;
    return it;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Stimulus: directed corners, then random items
  initial begin
    cau_pkg::in_item_t it;
    pending_items.push_back(make_item(cau_pkg::OP_ADD, 32'h7FFFFFFF, 32'h80000000,
                                      32'h1, 32'hFFFFFFFF));
    pending_items.push_back(make_item(cau_pkg::OP_ADD, 32'h00010000, 32'h00020000,
                                      32'h3, 32'h4));
    pending_items.push_back(make_item(cau_pkg::OP_SUB, 32'h80000000, 32'h7FFFFFFF,
                                      32'h1, 32'hFFFFFFFF));
    pending_items.push_back(make_item(cau_pkg::OP_SUB, 32'h5, 32'h6, 32'h7, 32'h8));
    pending_items.push_back(make_item(cau_pkg::OP_MUL, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000));
    pending_items.push_back(make_item(cau_pkg::OP_MUL, 32'hFFFFFFFF, 32'h1,
                                      32'h1, 32'hFFFFFFFF));
    pending_items.push_back(make_item(cau_pkg::OP_MUL, 32'h00018000, 32'hFFFF0000,
                                      32'h00020000, 32'h00008000));
    pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h00010000, 32'hFFFF0000,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h80000000, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h1, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000));
    pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h00030000, 32'h00040000,
                                      32'h00010000, 32'hFFFF0000));
    pending_items.push_back(make_item(cau_pkg::OP_MAG, 32'h80000000, 32'h80000000,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_MAG, 32'h00030000, 32'h00040000,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_MAG, 32'h0, 32'h0,
                                      32'hFFFFFFFF, 32'hFFFFFFFF));
    pending_items.push_back(make_item(cau_pkg::OP_PHASE, 32'h0, 32'h0, 32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_PHASE, 32'hFFFF0000, 32'h0,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_PHASE, 32'hFFFF0000, 32'hFFFFFFFF,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_PHASE, 32'h80000000, 32'h7FFFFFFF,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_PHASE, 32'h0, 32'h80000000,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(cau_pkg::OP_PHASE, 32'h7FFFFFFF, 32'h1,
                                      32'h0, 32'h0));
    pending_items.push_back(make_item(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h1));
    pending_items.push_back(make_item(3'd7, 32'h1, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFF));
    for (int n = 0; n < 500; n++) begin
      it.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
      it.a_re = rand_word(); it.a_im = rand_word();
      it.b_re = rand_word(); it.b_im = rand_word();
      if (it.operation == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
        it.b_re = 0; it.b_im = 0;
      end
      pending_items.push_back(it);
    end
    stim_done = 1'b1;
  end

  // Driver: offers items with random gaps, holds payload until accepted
  int drive_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      operand_valid <= 1'b0;
    end else begin
      if (operand_valid && operand_ready) begin
        expected_results.push_back(predict_result(operand));
        op_seen[operand.operation]++;
        accepted_in++;
      end
      if (!operand_valid || operand_ready) begin
        if (drive_gap > 0) begin
          drive_gap--;
          operand_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          operand <= pending_items.pop_front();
          operand_valid <= 1'b1;
          drive_gap = gap_len();
        end else begin
          operand_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off once well into the run so the pipeline backs up
  int hold_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      hold_active <= 1'b0;
    end else if (!hold_done && accepted_in >= 60) begin
      hold_active <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      hold_active <= 1'b0;
    end
  end

  // Monitor: compares results with the oldest expectation, stalls at random
  int stall_len = 0;
  cau_pkg::out_item_t exp_item;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        accepted_out++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result re=%h im=%h", $time, result.result_re,
                   result.result_im);
        end else begin
          exp_item = expected_results.pop_front();
          if (result !== exp_item) begin
            errors++;
            $display({"%0t: mismatch expected re=%h im=%h sat=%b dz=%b",
                      " actual re=%h im=%h sat=%b dz=%b"},
                     $time, exp_item.result_re, exp_item.result_im, exp_item.saturated,
                     exp_item.divide_by_zero, result.result_re, result.result_im,
                     result.saturated, result.divide_by_zero);
          end
        end
      end
      if (hold_active) begin
        result_ready <= 1'b0;
      end else if (stall_len > 0) begin
        stall_len--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_len = gap_len();
      end
    end
  end

  // Watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((operand_valid && operand_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (stim_done && pending_items.size() == 0 && !operand_valid
              && expected_results.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog timeout, %0d results still expected", $time,
                 expected_results.size());
        $display("testbench NOT OK");
        $finish;
      end
    join_any
    if (expected_results.size() != 0) errors++;
    $display("Ran %0d items (add %0d sub %0d mul %0d div %0d mag %0d phase %0d unused %0d),",
             accepted_in, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5], op_seen[6] + op_seen[7]);
    $display("checked %0d results with random stalls and one long output hold.", accepted_out);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
